### rtl/bilinear_image_upscaler_defines.svh
// assertion macros for the bilinear image upscaler
// included by the rtl files that carry concurrent checks, no other dependencies
`ifndef BILINEAR_IMAGE_UPSCALER_DEFINES_SVH
`define BILINEAR_IMAGE_UPSCALER_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define BIU_ASSERT_CLK(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

`define BIU_ASSERT(name, prop, msg) \
    `BIU_ASSERT_CLK(name, aclk, aresetn, prop, msg)

`else

`define BIU_ASSERT_CLK(name, clk, rstn, prop, msg)

`define BIU_ASSERT(name, prop, msg)

`endif

`endif

### rtl/biu_pkg.sv
// shared constants and types of the bilinear image upscaler
// no dependencies
`default_nettype none

package biu_pkg;

    localparam int DEF_MAX_SOURCE_DIM = 256;
    localparam int DEF_MAX_DEST_DIM   = 1024;
    localparam int DEF_PIXEL_BITS     = 8;
    localparam int DEF_FRACTION_BITS  = 16;

    localparam int DIM_REG_BITS   = 9;
    localparam int STEP_BITS      = 24;
    localparam int CFG_DATA_BITS  = 24;
    localparam int CFG_INDEX_BITS = 2;

    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

    localparam cfg_index_t CFG_SOURCE_WIDTH    = 2'd0;
    localparam cfg_index_t CFG_SOURCE_HEIGHT   = 2'd1;
    localparam cfg_index_t CFG_HORIZONTAL_STEP = 2'd2;
    localparam cfg_index_t CFG_VERTICAL_STEP   = 2'd3;

    localparam logic [DIM_REG_BITS-1:0] DIM_RESET  = 9'd256;
    localparam logic [STEP_BITS-1:0]    STEP_RESET = 24'd0;

    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    localparam int NEIGHBORS = 4;

endpackage

`default_nettype wire

### rtl/biu_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module biu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/bilinear_image_upscaler.sv
// Bilinear image upscaler. An op 0 transfer writes one source pixel into the
// frame store at row * width + col (ignored outside the image); an op 1 transfer
// maps a destination row and column through the Q16 step registers to a source
// point, reads the four neighbours and returns their weighted sum, truncated to
// a pixel. One item is accepted every cycle; a request passes through the pipeline
// stages and gives its result from the output register, and a stalled output
// only holds back new items once every pipeline stage is full. The frame store
// is four replicas of one memory, each with one read port, so that all four
// neighbours are read in the same cycle; writes go to every replica. The store
// has no clearing pass: an entry reads as undefined until it is written.
// Depends on biu_pkg, biu_ram and bilinear_image_upscaler_defines.svh.
`include "bilinear_image_upscaler_defines.svh"
`default_nettype none

module bilinear_image_upscaler
    import biu_pkg::*;
#(
    parameter int MAX_SOURCE_DIM = DEF_MAX_SOURCE_DIM,
    parameter int MAX_DEST_DIM   = DEF_MAX_DEST_DIM,
    parameter int PIXEL_BITS     = DEF_PIXEL_BITS,
    parameter int FRACTION_BITS  = DEF_FRACTION_BITS
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,

    input  wire logic                            cfg_wr_en,
    input  wire cfg_index_t                      cfg_wr_index,
    input  wire logic [CFG_DATA_BITS-1:0]        cfg_wr_data,

    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic                            s_op,
    input  wire logic [$clog2(MAX_DEST_DIM)-1:0] s_row,
    input  wire logic [$clog2(MAX_DEST_DIM)-1:0] s_col,
    input  wire logic [PIXEL_BITS-1:0]           s_pixel_in,

    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic      [PIXEL_BITS-1:0]           m_pixel_out
);

    localparam int COORD_BITS  = $clog2(MAX_DEST_DIM);
    localparam int IDX_BITS    = $clog2(MAX_SOURCE_DIM);
    localparam int ED_BITS     = $clog2(MAX_SOURCE_DIM + 1);
    localparam int STORE_DEPTH = MAX_SOURCE_DIM * MAX_SOURCE_DIM;
    localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
    localparam int POS_BITS    = COORD_BITS + STEP_BITS;
    localparam int INT_BITS    = POS_BITS - FRACTION_BITS;
    localparam int ROWOFF_BITS = COORD_BITS + ED_BITS;
    localparam int WT_BITS     = 2 * FRACTION_BITS + 1;
    localparam int SUM_BITS    = 2 * FRACTION_BITS + PIXEL_BITS;

    localparam logic [FRACTION_BITS:0] FRAC_ONE = {1'b1, {FRACTION_BITS{1'b0}}};
    localparam logic [WT_BITS+1:0]     WT_ONE   = (WT_BITS + 2)'(1) << (2 * FRACTION_BITS);

    // configuration registers
    logic [DIM_REG_BITS-1:0] src_width_reg;
    logic [DIM_REG_BITS-1:0] src_height_reg;
    logic [STEP_BITS-1:0]    h_step_reg;
    logic [STEP_BITS-1:0]    v_step_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_width_reg  <= DIM_RESET;
            src_height_reg <= DIM_RESET;
            h_step_reg     <= STEP_RESET;
            v_step_reg     <= STEP_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_SOURCE_WIDTH:    src_width_reg  <= cfg_wr_data[DIM_REG_BITS-1:0];
                CFG_SOURCE_HEIGHT:   src_height_reg <= cfg_wr_data[DIM_REG_BITS-1:0];
                CFG_HORIZONTAL_STEP: h_step_reg     <= cfg_wr_data[STEP_BITS-1:0];
                CFG_VERTICAL_STEP:   v_step_reg     <= cfg_wr_data[STEP_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // effective dimensions, zero acts as one and large values saturate
    logic [ED_BITS-1:0]  eff_w;
    logic [ED_BITS-1:0]  eff_h;
    logic [IDX_BITS-1:0] last_col;
    logic [IDX_BITS-1:0] last_row;

    always_comb begin
        if (src_width_reg == '0) begin
            eff_w = ED_BITS'(1);
        end else if (int'(src_width_reg) > MAX_SOURCE_DIM) begin
            eff_w = ED_BITS'(MAX_SOURCE_DIM);
        end else begin
            eff_w = ED_BITS'(src_width_reg);
        end
        if (src_height_reg == '0) begin
            eff_h = ED_BITS'(1);
        end else if (int'(src_height_reg) > MAX_SOURCE_DIM) begin
            eff_h = ED_BITS'(MAX_SOURCE_DIM);
        end else begin
            eff_h = ED_BITS'(src_height_reg);
        end
        last_col = IDX_BITS'(eff_w - ED_BITS'(1));
        last_row = IDX_BITS'(eff_h - ED_BITS'(1));
    end

    // stage valids and enables
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, m_valid_reg;
    logic en1, en2, en3, en4, en5, en6, en_out;

    assign en_out = !m_valid_reg || m_ready;
    assign en6    = !v6_reg || en_out;
    assign en5    = !v5_reg || en6;
    assign en4    = !v4_reg || en5;
    assign en3    = !v3_reg || en4;
    assign en2    = !v2_reg || en3;
    assign en1    = !v1_reg || en2;

    assign s_ready = en1;
    assign m_valid = m_valid_reg;

    logic op1_reg, op2_reg, op3_reg, op4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            v6_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            // write items leave the pipeline once the store has taken them
            if (en5) v5_reg <= v4_reg && (op4_reg == OP_REQUEST);
            if (en6) v6_reg <= v5_reg;
            if (en_out) m_valid_reg <= v6_reg;
        end
    end

    // stage 1: accepted transfer
    logic [COORD_BITS-1:0] row1_reg, col1_reg;
    logic [PIXEL_BITS-1:0] pix1_reg;

    always_ff @(posedge aclk) begin
        if (en1) begin
            op1_reg  <= s_op;
            row1_reg <= s_row;
            col1_reg <= s_col;
            pix1_reg <= s_pixel_in;
        end
    end

    // stage 2: source position and write row offset
    logic [POS_BITS-1:0]    xp_next, yp_next;
    logic [ROWOFF_BITS-1:0] wrow_next;
    logic [POS_BITS-1:0]    xp2_reg, yp2_reg;
    logic [ROWOFF_BITS-1:0] wrow2_reg;
    logic [COORD_BITS-1:0]  row2_reg, col2_reg;
    logic [PIXEL_BITS-1:0]  pix2_reg;

    assign xp_next   = POS_BITS'(col1_reg) * POS_BITS'(h_step_reg);
    assign yp_next   = POS_BITS'(row1_reg) * POS_BITS'(v_step_reg);
    assign wrow_next = ROWOFF_BITS'(row1_reg) * ROWOFF_BITS'(eff_w);

    always_ff @(posedge aclk) begin
        if (en2) begin
            op2_reg   <= op1_reg;
            xp2_reg   <= xp_next;
            yp2_reg   <= yp_next;
            wrow2_reg <= wrow_next;
            row2_reg  <= row1_reg;
            col2_reg  <= col1_reg;
            pix2_reg  <= pix1_reg;
        end
    end

    // stage 3: clamped neighbour indices, fractions, write address
    logic [INT_BITS-1:0]      xi, yi;
    logic [IDX_BITS-1:0]      x0_next, x1_next, y0_next, y1_next;
    logic                     wr_ok_next;
    logic [ADDR_BITS-1:0]     waddr_next;
    logic [IDX_BITS-1:0]      x0_3_reg, x1_3_reg, y0_3_reg, y1_3_reg;
    logic [FRACTION_BITS-1:0] fx3_reg, fy3_reg;
    logic                     wr_ok3_reg;
    logic [ADDR_BITS-1:0]     waddr3_reg;
    logic [PIXEL_BITS-1:0]    pix3_reg;

    always_comb begin
        xi = xp2_reg[POS_BITS-1:FRACTION_BITS];
        yi = yp2_reg[POS_BITS-1:FRACTION_BITS];
        x0_next = (xi > INT_BITS'(last_col)) ? last_col : IDX_BITS'(xi);
        y0_next = (yi > INT_BITS'(last_row)) ? last_row : IDX_BITS'(yi);
        x1_next = (x0_next < last_col) ? x0_next + IDX_BITS'(1) : last_col;
        y1_next = (y0_next < last_row) ? y0_next + IDX_BITS'(1) : last_row;
        wr_ok_next = (row2_reg < eff_h) && (col2_reg < eff_w);
        waddr_next = ADDR_BITS'(wrow2_reg + ROWOFF_BITS'(col2_reg));
    end

    always_ff @(posedge aclk) begin
        if (en3) begin
            op3_reg    <= op2_reg;
            x0_3_reg   <= x0_next;
            x1_3_reg   <= x1_next;
            y0_3_reg   <= y0_next;
            y1_3_reg   <= y1_next;
            fx3_reg    <= xp2_reg[FRACTION_BITS-1:0];
            fy3_reg    <= yp2_reg[FRACTION_BITS-1:0];
            wr_ok3_reg <= wr_ok_next;
            waddr3_reg <= waddr_next;
            pix3_reg   <= pix2_reg;
        end
    end

    // stage 4: row offsets of the neighbours and the four weights
    logic [FRACTION_BITS:0] gx, gy;
    logic [WT_BITS-1:0]     wt_next [NEIGHBORS];
    logic [ADDR_BITS-1:0]   y0w_next, y1w_next;
    logic [ADDR_BITS-1:0]   y0w4_reg, y1w4_reg;
    logic [IDX_BITS-1:0]    x0_4_reg, x1_4_reg;
    logic [WT_BITS-1:0]     wt4_reg [NEIGHBORS];
    logic                   wr_ok4_reg;
    logic [ADDR_BITS-1:0]   waddr4_reg;
    logic [PIXEL_BITS-1:0]  pix4_reg;

    always_comb begin
        gx = FRAC_ONE - {1'b0, fx3_reg};
        gy = FRAC_ONE - {1'b0, fy3_reg};
        wt_next[0] = WT_BITS'(gx) * WT_BITS'(gy);
        wt_next[1] = WT_BITS'(fx3_reg) * WT_BITS'(gy);
        wt_next[2] = WT_BITS'(gx) * WT_BITS'(fy3_reg);
        wt_next[3] = WT_BITS'(fx3_reg) * WT_BITS'(fy3_reg);
        y0w_next = ADDR_BITS'(y0_3_reg) * ADDR_BITS'(eff_w);
        y1w_next = ADDR_BITS'(y1_3_reg) * ADDR_BITS'(eff_w);
    end

    always_ff @(posedge aclk) begin
        if (en4) begin
            op4_reg    <= op3_reg;
            y0w4_reg   <= y0w_next;
            y1w4_reg   <= y1w_next;
            x0_4_reg   <= x0_3_reg;
            x1_4_reg   <= x1_3_reg;
            wt4_reg    <= wt_next;
            wr_ok4_reg <= wr_ok3_reg;
            waddr4_reg <= waddr3_reg;
            pix4_reg   <= pix3_reg;
        end
    end

    // frame store: writes and neighbour reads share this stage, so a later
    // request always sees an earlier write through the registered read
    logic [ADDR_BITS-1:0]  rd_addr [NEIGHBORS];
    logic [PIXEL_BITS-1:0] rd_data [NEIGHBORS];
    logic                  store_we;

    assign rd_addr[0] = y0w4_reg + ADDR_BITS'(x0_4_reg);
    assign rd_addr[1] = y0w4_reg + ADDR_BITS'(x1_4_reg);
    assign rd_addr[2] = y1w4_reg + ADDR_BITS'(x0_4_reg);
    assign rd_addr[3] = y1w4_reg + ADDR_BITS'(x1_4_reg);
    assign store_we   = v4_reg && (op4_reg == OP_WRITE) && wr_ok4_reg && en5;

    for (genvar g = 0; g < NEIGHBORS; g++) begin : g_store
        biu_ram #(
            .WIDTH (PIXEL_BITS),
            .DEPTH (STORE_DEPTH)
        ) u_store (
            .clk     (aclk),
            .wr_en   (store_we),
            .wr_addr (waddr4_reg),
            .wr_data (pix4_reg),
            .rd_en   (en5),
            .rd_addr (rd_addr[g]),
            .rd_data (rd_data[g])
        );
    end

    // stage 5: neighbour pixels arrive, weighted products
    logic [WT_BITS-1:0]  wt5_reg [NEIGHBORS];
    logic [SUM_BITS-1:0] prod_next [NEIGHBORS];
    logic [SUM_BITS-1:0] prod6_reg [NEIGHBORS];

    always_ff @(posedge aclk) begin
        if (en5) begin
            wt5_reg <= wt4_reg;
        end
    end

    always_comb begin
        for (int k = 0; k < NEIGHBORS; k++) begin
            prod_next[k] = SUM_BITS'(rd_data[k]) * SUM_BITS'(wt5_reg[k]);
        end
    end

    // stage 6: products, summed into the output register
    always_ff @(posedge aclk) begin
        if (en6) begin
            prod6_reg <= prod_next;
        end
    end

    logic [SUM_BITS-1:0]   sum_next;
    logic [PIXEL_BITS-1:0] m_pixel_out_reg;

    assign sum_next = prod6_reg[0] + prod6_reg[1] + prod6_reg[2] + prod6_reg[3];

    always_ff @(posedge aclk) begin
        if (en_out && v6_reg) begin
            m_pixel_out_reg <= sum_next[SUM_BITS-1:2*FRACTION_BITS];
        end
    end

    assign m_pixel_out = m_pixel_out_reg;

    // checks
    logic [WT_BITS+1:0] wt_total;
    logic               pipe_full;
    logic               x_adjacent;
    logic               y_adjacent;

    assign wt_total = (WT_BITS + 2)'(wt4_reg[0]) + (WT_BITS + 2)'(wt4_reg[1])
                    + (WT_BITS + 2)'(wt4_reg[2]) + (WT_BITS + 2)'(wt4_reg[3]);
    assign pipe_full = v1_reg && v2_reg && v3_reg && v4_reg && v5_reg && v6_reg
                    && m_valid_reg && !m_ready;
    assign x_adjacent = (x1_3_reg == x0_3_reg) || (x1_3_reg == x0_3_reg + IDX_BITS'(1));
    assign y_adjacent = (y1_3_reg == y0_3_reg) || (y1_3_reg == y0_3_reg + IDX_BITS'(1));

    `BIU_ASSERT(a_stall_only_when_full, !s_ready |-> pipe_full, "input stalled with a free stage")
    `BIU_ASSERT(a_neighbor_adjacent, (v3_reg && op3_reg == OP_REQUEST) |-> (x_adjacent && y_adjacent), "neighbour indices not adjacent")
    `BIU_ASSERT(a_weights_sum_to_one, (v4_reg && op4_reg == OP_REQUEST) |-> (wt_total == WT_ONE), "bilinear weights do not sum to one")

endmodule

`default_nettype wire
